/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* design/bvo_pkg.sv */
// ----------------------------------------------------------------------------
// Bounding volume overlap package
// Pair kinds, control bundle and default geometry constants.
// ----------------------------------------------------------------------------
package bvo_pkg;

    // Total bits of one signed coordinate lane (Q12.8 by default).
    localparam int COORD_BITS_DEF = 20;
    localparam int LANES          = 3;
    localparam int KIND_BITS      = 3;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_SPH_SPH = 3'd0,
        KIND_SPH_BOX = 3'd1,
        KIND_SPH_CYL = 3'd2,
        KIND_CYL_BOX = 3'd3,
        KIND_CYL_CYL = 3'd4,
        KIND_BOX_BOX = 3'd5
    } bvo_kind_t;

    // Control that travels with the distance terms down the pipeline.
    typedef struct packed {
        logic strict;   // distance test uses < instead of <=
        logic gate;     // all non-distance tests passed
    } bvo_ctrl_t;

endpackage

/* design/bvo_req_if.sv */
// ----------------------------------------------------------------------------
// Overlap request channel
// Valid/ready channel carrying one pair of bounding volumes.
// ----------------------------------------------------------------------------
interface bvo_req_if #(
    parameter int COORD_BITS = bvo_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [bvo_pkg::KIND_BITS-1:0] req_type;
    logic [3*COORD_BITS-1:0]       a_point;
    logic [3*COORD_BITS-1:0]       a_size;
    logic [3*COORD_BITS-1:0]       b_point;
    logic [3*COORD_BITS-1:0]       b_size;

    modport source (output valid, req_type, a_point, a_size, b_point, b_size, input ready);
    modport sink   (input valid, req_type, a_point, a_size, b_point, b_size, output ready);
endinterface

/* design/bvo_res_if.sv */
// ----------------------------------------------------------------------------
// Overlap result channel
// Valid/ready channel carrying one overlap verdict.
// ----------------------------------------------------------------------------
interface bvo_res_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink   (input valid, hit, output ready);
endinterface

/* design/bounding_volume_overlap_test.sv */
// Path: a request moves through v1_reg, v2_reg and vo_reg on its way to res.
// Throughput: one pair per cycle unless res.ready stalls; three register
// stages (setup, squares, sum and compare); each moves when the next is free.
// Reset: asynchronous active-low rst_n empties every stage; no results are
// pending and req.ready is high once reset is released.
// ----------------------------------------------------------------------------
// Bounding volume overlap test
// Streams sphere, cylinder and box pairs and reports whether they overlap.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounding_volume_overlap_test #(
    parameter int COORD_BITS = bvo_pkg::COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    bvo_req_if.sink   req,
    bvo_res_if.source res
);
    import bvo_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int SQ_W  = 2 * C + 1;
    localparam int SUM_W = SQ_W + 2;

    // Stage 1: distance terms and interval outcomes.
    logic signed [C:0]   t_next [LANES];
    logic [C:0]          bound_next;
    bvo_ctrl_t           ctrl_next;
    logic                v1_reg;
    logic signed [C:0]   t_reg [LANES];
    logic [C:0]          bound_reg;
    bvo_ctrl_t           ctrl1_reg;

    // Stage 2: squared terms.
    logic signed [2*C+1:0] prod [LANES];
    logic [2*C+1:0]        bound_sq;
    logic                  v2_reg;
    logic [SQ_W-1:0]       sq_reg [LANES];
    logic [SQ_W-1:0]       bsq_reg;
    bvo_ctrl_t             ctrl2_reg;

    // Stage 3: verdict.
    logic [SUM_W-1:0] dist_sum;
    logic             hit_next;
    logic             vo_reg;
    logic             hit_reg;

    logic adv1;
    logic adv2;
    logic adv3;
    logic load1;

    assign adv3  = !vo_reg || res.ready;
    assign adv2  = !v2_reg || adv3;
    assign adv1  = !v1_reg || adv2;
    assign load1 = req.valid && req.ready;

    assign req.ready = adv1;

    bvo_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .req_type (req.req_type),
        .a_point  (req.a_point),
        .a_size   (req.a_size),
        .b_point  (req.b_point),
        .b_size   (req.b_size),
        .term0    (t_next[0]),
        .term1    (t_next[1]),
        .term2    (t_next[2]),
        .bound    (bound_next),
        .ctrl     (ctrl_next)
    );

    for (genvar k = 0; k < LANES; k++)
    begin : g_sq
        assign prod[k] = t_reg[k] * t_reg[k];
    end
    assign bound_sq = (2*C+2)'(bound_reg) * (2*C+2)'(bound_reg);

    assign dist_sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    assign hit_next = ctrl2_reg.gate &&
                      (ctrl2_reg.strict ? (dist_sum < SUM_W'(bsq_reg))
                                        : (dist_sum <= SUM_W'(bsq_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= load1;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                vo_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            t_reg     <= t_next;
            bound_reg <= bound_next;
            ctrl1_reg <= ctrl_next;
        end
        if (adv2 && v1_reg)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                sq_reg[k] <= prod[k][SQ_W-1:0];
            end
            bsq_reg   <= bound_sq[SQ_W-1:0];
            ctrl2_reg <= ctrl1_reg;
        end
        if (adv3 && v2_reg)
            hit_reg <= hit_next;
    end

    assign res.valid = vo_reg;
    assign res.hit   = hit_reg;

    // A request is refused only when every stage is full and the output stalls.
    `ASSERT_SAME(a_ready_full, clk, rst_n, !req.ready,
                 v1_reg && v2_reg && vo_reg && !res.ready)

    // An unused pair kind enters stage 1 with its gate closed.
    `ASSERT_NEXT(a_unused_kind, clk, rst_n,
                 load1 && (req.req_type > KIND_BOX_BOX),
                 v1_reg && !ctrl1_reg.gate)

    // Anything moving out of the square stage shows up as a result.
    `ASSERT_NEXT(a_stage_flow, clk, rst_n, adv3 && v2_reg, res.valid)

endmodule

/* design/bvo_geom.sv */
// ----------------------------------------------------------------------------
// Overlap geometry setup
// Unpacks the lanes of one pair and reduces it, per pair kind, to three
// signed distance terms, a radius bound and the outcome of the interval tests.
// ----------------------------------------------------------------------------
module bvo_geom #(
    parameter int COORD_BITS = bvo_pkg::COORD_BITS_DEF
) (
    input  logic [bvo_pkg::KIND_BITS-1:0] req_type,
    input  logic [3*COORD_BITS-1:0]       a_point,
    input  logic [3*COORD_BITS-1:0]       a_size,
    input  logic [3*COORD_BITS-1:0]       b_point,
    input  logic [3*COORD_BITS-1:0]       b_size,
    output logic signed [COORD_BITS:0]    term0,
    output logic signed [COORD_BITS:0]    term1,
    output logic signed [COORD_BITS:0]    term2,
    output logic [COORD_BITS:0]           bound,
    output bvo_pkg::bvo_ctrl_t            ctrl
);
    import bvo_pkg::*;

    localparam int C = COORD_BITS;
    localparam int W = C + 2;

    logic signed [W-1:0] pa [LANES];
    logic signed [W-1:0] sa [LANES];
    logic signed [W-1:0] pb [LANES];
    logic signed [W-1:0] sb [LANES];
    logic signed [W-1:0] ra;
    logic signed [W-1:0] ha;
    logic signed [W-1:0] rb;
    logic signed [W-1:0] hb;
    logic signed [W-1:0] d [LANES];
    logic signed [W-1:0] rr;

    // Offset of p outside [lo, hi], zero when inside.
    function automatic logic signed [W-1:0] gap(
        input logic signed [W-1:0] p,
        input logic signed [W-1:0] lo,
        input logic signed [W-1:0] hi
    );
        logic signed [W-1:0] g;
        begin
            if (p < lo)
                g = p - lo;
            else if (p > hi)
                g = p - hi;
            else
                g = '0;
            return g;
        end
    endfunction

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        assign pa[k] = W'(signed'(a_point[k*C +: C]));
        assign sa[k] = W'(signed'(a_size[k*C +: C]));
        assign pb[k] = W'(signed'(b_point[k*C +: C]));
        assign sb[k] = W'(signed'(b_size[k*C +: C]));
    end

    // Negative radii and heights count as zero.
    assign ra = sa[0][W-1] ? '0 : sa[0];
    assign ha = sa[1][W-1] ? '0 : sa[1];
    assign rb = sb[0][W-1] ? '0 : sb[0];
    assign hb = sb[1][W-1] ? '0 : sb[1];

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            d[k] = '0;
        end
        rr          = '0;
        ctrl.strict = 1'b0;
        ctrl.gate   = 1'b0;
        case (bvo_kind_t'(req_type))
            KIND_SPH_SPH:
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    d[k] = pb[k] - pa[k];
                end
                rr          = ra + rb;
                ctrl.strict = 1'b1;
                ctrl.gate   = 1'b1;
            end
            KIND_SPH_BOX:
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    d[k] = gap(pa[k], pb[k], sb[k]);
                end
                rr        = ra;
                ctrl.gate = 1'b1;
            end
            KIND_SPH_CYL:
            begin
                d[0]      = pb[0] - pa[0];
                d[2]      = pb[2] - pa[2];
                rr        = ra + rb;
                ctrl.gate = (pa[1] + ra >= pb[1]) && (pa[1] - ra <= pb[1] + hb);
            end
            KIND_CYL_BOX:
            begin
                d[0]      = gap(pa[0], pb[0], sb[0]);
                d[2]      = gap(pa[2], pb[2], sb[2]);
                rr        = ra;
                ctrl.gate = (sb[1] >= pa[1]) && (pb[1] <= pa[1] + ha);
            end
            KIND_CYL_CYL:
            begin
                d[0]      = pb[0] - pa[0];
                d[2]      = pb[2] - pa[2];
                rr        = ra + rb;
                ctrl.gate = (pa[1] + ha >= pb[1]) && (pb[1] + hb >= pa[1]);
            end
            KIND_BOX_BOX:
            begin
                // Zero terms against a zero bound always pass the distance test.
                ctrl.gate = 1'b1;
                for (int k = 0; k < LANES; k++)
                begin
                    if (pa[k] > sb[k] || pb[k] > sa[k])
                        ctrl.gate = 1'b0;
                end
            end
            default:
            begin
                ctrl.gate = 1'b0;
            end
        endcase
    end

    assign term0 = signed'(d[0][C:0]);
    assign term1 = signed'(d[1][C:0]);
    assign term2 = signed'(d[2][C:0]);
    assign bound = rr[C:0];

endmodule
